[hw/rtl/dpfr_pkg.sv]
// shared types and constants of the dual-protocol frame receiver
`timescale 1ns / 1ps

package dpfr_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 19;
  localparam int unsigned PREAMBLE_LEN    = 3;

  localparam logic [23:0] PREAMBLE_WORD = 24'h550100;
  localparam logic [7:0]  PREAMBLE_B0   = 8'h55;
  localparam logic [7:0]  PREAMBLE_B1   = 8'h01;
  localparam logic [7:0]  PREAMBLE_B2   = 8'h00;

  localparam logic [7:0]  SINGLE_LO = 8'h30;
  localparam logic [7:0]  SINGLE_HI = 8'h37;
  localparam logic [7:0]  PAIR_HI   = 8'h3A;

  localparam logic [4:0]  SHORT_SIZE_ONE = 5'd1;
  localparam logic [4:0]  SHORT_SIZE_TWO = 5'd2;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_SINGLE,
    EV_PAIR,
    EV_FRAME
  } dpfr_ev_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SECOND,
    ST_FRAME_RD,
    ST_FRAME_LD
  } dpfr_state_e;

  typedef struct packed {
    logic take_item;
    logic load_single;
    logic load_first;
    logic load_second;
    logic load_frame;
    logic idx_clr;
    logic idx_inc;
  } dpfr_cmd_t;

  typedef struct packed {
    dpfr_ev_e ev;
    logic     out_free;
    logic     idx_last;
  } dpfr_status_t;

endpackage

[hw/rtl/dpfr_ctrl.sv]
// controller state machine: item intake and emission sequencing
`timescale 1ns / 1ps

module dpfr_ctrl import dpfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  dpfr_status_t status_i,
  output dpfr_cmd_t    cmd_o
);

  dpfr_state_e state_q, state_d;
  logic        take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign take = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // the output register must be free so a short message can load at once
        in_ready_o      = status_i.out_free;
        cmd_o.take_item = take;
        if (take) begin
          unique case (status_i.ev)
            EV_SINGLE: cmd_o.load_single = 1'b1;
            EV_PAIR: begin
              cmd_o.load_first = 1'b1;
              state_d          = ST_SECOND;
            end
            EV_FRAME: begin
              cmd_o.idx_clr = 1'b1;
              state_d       = ST_FRAME_RD;
            end
            default: ;
          endcase
        end
      end
      ST_SECOND: begin
        if (status_i.out_free) begin
          cmd_o.load_second = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_FRAME_RD: begin
        state_d = ST_FRAME_LD;
      end
      ST_FRAME_LD: begin
        if (status_i.out_free) begin
          cmd_o.load_frame = 1'b1;
          if (status_i.idx_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_FRAME_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_frame_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && status_i.ev == EV_FRAME) |=> state_q == ST_FRAME_RD)
    else $error("frame completion did not start emission");

  a_pair_goes_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && status_i.ev == EV_PAIR) |=> state_q == ST_SECOND)
    else $error("two-byte message did not queue its second word");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_frame && status_i.idx_last) |=> state_q == ST_IDLE)
    else $error("frame emission did not end on its last word");

endmodule

[hw/rtl/dpfr_datapath.sv]
// datapath: sync window, frame memory, short-message state, output register
`timescale 1ns / 1ps

module dpfr_datapath import dpfr_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_wr_i,
  input  logic         cfg_data_i,
  input  logic [7:0]   rx_byte_i,
  input  logic         rx_parity_i,
  input  dpfr_cmd_t    cmd_i,
  output dpfr_status_t status_o,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic [7:0]   out_byte_o,
  output logic [4:0]   byte_index_o,
  output logic [4:0]   message_size_o,
  output logic         last_of_run_o
);

  localparam int unsigned IDXW = $clog2(FRAME_BYTES);

  logic            proto_q;
  logic [23:0]     win_q, win_d, win_shift;
  logic            coll_q, coll_d;
  logic [IDXW-1:0] fill_q, fill_d;
  logic            pend_q, pend_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      second_q;
  logic            mem_we;
  dpfr_ev_e        ev;

  logic [7:0]      mem_q [FRAME_BYTES];
  logic [7:0]      rd_data_q;
  logic [IDXW-1:0] idx_q;
  logic [7:0]      frame_byte;

  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic [4:0]      out_idx_q, out_size_q;
  logic            out_last_q;
  logic            any_load;

  assign win_shift = {win_q[15:0], rx_byte_i};

  always_comb begin
    win_d   = win_q;
    coll_d  = coll_q;
    fill_d  = fill_q;
    pend_d  = pend_q;
    first_d = first_q;
    mem_we  = 1'b0;
    ev      = EV_NONE;
    if (proto_q) begin
      if (!coll_q) begin
        win_d = win_shift;
        if (win_shift == PREAMBLE_WORD) begin
          fill_d = IDXW'(PREAMBLE_LEN);
          coll_d = 1'b1;
        end
      end else begin
        mem_we = 1'b1;
        if (fill_q == IDXW'(FRAME_BYTES - 1)) begin
          coll_d = 1'b0;
          win_d  = '0;
          fill_d = '0;
          ev     = EV_FRAME;
        end else begin
          fill_d = fill_q + IDXW'(1);
        end
      end
    end else if (rx_parity_i != ^rx_byte_i) begin
      // parity error drops a partial message
      pend_d = 1'b0;
    end else if (!pend_q) begin
      if (rx_byte_i >= SINGLE_LO && rx_byte_i <= SINGLE_HI) begin
        first_d = rx_byte_i;
        ev      = EV_SINGLE;
      end else if (rx_byte_i > SINGLE_HI && rx_byte_i <= PAIR_HI) begin
        first_d = rx_byte_i;
        pend_d  = 1'b1;
      end
    end else begin
      pend_d = 1'b0;
      ev     = EV_PAIR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_q <= 1'b0;
      win_q   <= '0;
      coll_q  <= 1'b0;
      fill_q  <= '0;
      pend_q  <= 1'b0;
      first_q <= '0;
    end else begin
      if (cfg_wr_i) begin
        proto_q <= cfg_data_i;
      end
      if (cmd_i.take_item) begin
        win_q   <= win_d;
        coll_q  <= coll_d;
        fill_q  <= fill_d;
        pend_q  <= pend_d;
        first_q <= first_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      second_q <= rx_byte_i;
    end
  end

  // frame memory: one write port while collecting, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && mem_we) begin
      mem_q[fill_q] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IDXW'(1);
    end
  end

  // preamble entries are never written, they come from constants
  always_comb begin
    if (idx_q == IDXW'(0)) begin
      frame_byte = PREAMBLE_B0;
    end else if (idx_q == IDXW'(1)) begin
      frame_byte = PREAMBLE_B1;
    end else if (idx_q == IDXW'(2)) begin
      frame_byte = PREAMBLE_B2;
    end else begin
      frame_byte = rd_data_q;
    end
  end

  assign any_load = cmd_i.load_single || cmd_i.load_first ||
                    cmd_i.load_second || cmd_i.load_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (any_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_single) begin
      out_byte_q <= rx_byte_i;
      out_idx_q  <= 5'd0;
      out_size_q <= SHORT_SIZE_ONE;
      out_last_q <= 1'b1;
    end else if (cmd_i.load_first) begin
      out_byte_q <= first_q;
      out_idx_q  <= 5'd0;
      out_size_q <= SHORT_SIZE_TWO;
      out_last_q <= 1'b0;
    end else if (cmd_i.load_second) begin
      out_byte_q <= second_q;
      out_idx_q  <= 5'd1;
      out_size_q <= SHORT_SIZE_TWO;
      out_last_q <= 1'b1;
    end else if (cmd_i.load_frame) begin
      out_byte_q <= frame_byte;
      out_idx_q  <= 5'(idx_q);
      out_size_q <= 5'(FRAME_BYTES);
      out_last_q <= (idx_q == IDXW'(FRAME_BYTES - 1));
    end
  end

  assign status_o.ev       = ev;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.idx_last = (idx_q == IDXW'(FRAME_BYTES - 1));

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign byte_index_o   = out_idx_q;
  assign message_size_o = out_size_q;
  assign last_of_run_o  = out_last_q;

  a_fill_past_preamble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coll_q |-> fill_q >= IDXW'(PREAMBLE_LEN))
    else $error("collecting with fill count inside the preamble");

  a_frame_resets_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take_item && ev == EV_FRAME) |=> (!coll_q && win_q == '0 && fill_q == '0))
    else $error("frame completion left sync state behind");

  a_frame_mode_keeps_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take_item && proto_q) |=> ($stable(pend_q) && $stable(first_q)))
    else $error("frame-mode byte touched short-message state");

  a_frame_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_frame && status_o.idx_last) |=> (out_valid_q && out_last_q))
    else $error("last frame word not marked");

endmodule

[hw/rtl/dual_protocol_frame_receiver_top.sv]
// top level of the dual-protocol frame receiver
//
//  channel   | direction | handshake                    | payload
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata: rx_byte, rx_parity
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: out_byte, byte_index,
//            |           |                              | message_size; tlast: last_of_run
//  cfg       | in        | cfg_valid_i / cfg_ready_o    | cfg_data_i: protocol_select
//
// a short-mode word that completes a message loads the output register as it is taken
// a completed frame is sent as FRAME_BYTES words, each a frame memory read, then the
// output register load; input is held off meanwhile
// a result waiting in the output register holds off input; a new word is taken
// in the cycle that result leaves
// reset clears control state only; the frame memory is not cleared
`timescale 1ns / 1ps

module dual_protocol_frame_receiver_top import dpfr_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] rx_parity, [15:9] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [12:8] byte_index,
                                      // [17:13] message_size, [23:18] zero
  output logic        m_axis_tlast
);

  dpfr_cmd_t    cmd;
  dpfr_status_t status;
  logic [7:0]   out_byte;
  logic [4:0]   byte_index;
  logic [4:0]   message_size;

  assign cfg_ready_o = 1'b1;

  dpfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dpfr_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .rx_byte_i      (s_axis_tdata[7:0]),
    .rx_parity_i    (s_axis_tdata[8]),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_byte_o     (out_byte),
    .byte_index_o   (byte_index),
    .message_size_o (message_size),
    .last_of_run_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, message_size, byte_index, out_byte};

endmodule

[sim/tb_dual_protocol_frame_receiver_top.sv]
// self-checking testbench of the dual-protocol frame receiver top level
`timescale 1ns / 1ps

module tb_dual_protocol_frame_receiver_top;
  import dpfr_pkg::*;

  localparam int unsigned FB          = FRAME_BYTES_DEF;
  localparam int unsigned RAND_ITEMS  = 320;
  localparam int unsigned SETTLE_CYC  = 3 * FB + 20;
  localparam int unsigned HOLD_CYC    = 300;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam logic [7:0]  PAIR_LO     = SINGLE_HI + 8'd1;

  typedef struct packed {
    logic [7:0] data;
    logic [4:0] idx;
    logic [4:0] size;
    logic       last;
  } msg_word_t;

  class deframe_scoreboard;
    msg_word_t   expected_words[$];
    int unsigned errors;
    logic        proto;
    logic [23:0] sync_win;
    logic        collecting;
    int unsigned fill;
    logic [7:0]  frame_mem[FB];
    logic [7:0]  first_byte;
    logic        pair_open;

    function new();
      errors     = 0;
      proto      = 1'b0;
      sync_win   = '0;
      collecting = 1'b0;
      fill       = 0;
      first_byte = '0;
      pair_open  = 1'b0;
      foreach (frame_mem[i]) frame_mem[i] = '0;
      frame_mem[0] = PREAMBLE_B0;
      frame_mem[1] = PREAMBLE_B1;
      frame_mem[2] = PREAMBLE_B2;
    endfunction

    function void push_word(logic [7:0] d, logic [4:0] i, logic [4:0] s, logic l);
      msg_word_t w;
      w.data = d;
      w.idx  = i;
      w.size = s;
      w.last = l;
      expected_words.push_back(w);
    endfunction

    function void note_rx_byte(logic [7:0] b, logic p);
      if (proto) begin
        if (!collecting) begin
          sync_win = {sync_win[15:0], b};
          if (sync_win == PREAMBLE_WORD) begin
            fill       = PREAMBLE_LEN;
            collecting = 1'b1;
          end
          return;
        end
        if (fill < FB) frame_mem[fill] = b;
        fill++;
        if (fill >= FB) begin
          collecting = 1'b0;
          sync_win   = '0;
          fill       = 0;
          for (int k = 0; k < FB; k++) begin
            push_word(frame_mem[k], 5'(k), 5'(FB), k == FB - 1);
          end
        end
        return;
      end
      // short mode: even parity gate first
      if (p != ^b) begin
        pair_open = 1'b0;
        return;
      end
      if (!pair_open) begin
        if (b >= SINGLE_LO && b <= SINGLE_HI) begin
          first_byte = b;
          push_word(b, 5'd0, SHORT_SIZE_ONE, 1'b1);
        end else if (b >= PAIR_LO && b <= PAIR_HI) begin
          first_byte = b;
          pair_open  = 1'b1;
        end
        return;
      end
      pair_open = 1'b0;
      push_word(first_byte, 5'd0, SHORT_SIZE_TWO, 1'b0);
      push_word(b, 5'd1, SHORT_SIZE_TWO, 1'b1);
    endfunction

    function void check_word(logic [23:0] tdata, logic tlast);
      msg_word_t w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: data %h last %b", $time, tdata, tlast);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (tdata[7:0] !== w.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, w.data, tdata[7:0]);
        errors++;
      end
      if (tdata[12:8] !== w.idx) begin
        $display("%0t: byte_index expected %0d actual %0d", $time, w.idx, tdata[12:8]);
        errors++;
      end
      if (tdata[17:13] !== w.size) begin
        $display("%0t: message_size expected %0d actual %0d", $time, w.size, tdata[17:13]);
        errors++;
      end
      if (tlast !== w.last) begin
        $display("%0t: last_of_run expected %b actual %b", $time, w.last, tlast);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  deframe_scoreboard sb = new();

  bit          quiet;
  bit          burst;
  bit          hold_req;
  bit          tx_on;
  int unsigned rand_items;
  int unsigned idle_cycles;

  dual_protocol_frame_receiver_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // result side: checks every accepted word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
  end

  // receiver readiness: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(0, 40)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_rx(input logic [7:0] b, input logic p);
    s_axis_tdata  <= {7'b0, p, b};
    s_axis_tvalid <= 1'b1;
    tx_on = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_rx_byte(b, p);
    if (!quiet && !burst && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      tx_on = 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic send_good(input logic [7:0] b);
    send_rx(b, ^b);
  endtask

  task automatic send_bad(input logic [7:0] b);
    send_rx(b, ~(^b));
  endtask

  // lets every expected word out, then gives the block time to go idle
  task automatic settle();
    if (tx_on) begin
      s_axis_tvalid <= 1'b0;
      tx_on = 1'b0;
    end
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_protocol(input logic v);
    settle();
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.proto = v;
  endtask

  task automatic send_frame_body(input int unsigned n);
    repeat (n) send_rx(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_frame();
    send_rx(PREAMBLE_B0, 1'($urandom_range(0, 1)));
    send_rx(PREAMBLE_B1, 1'($urandom_range(0, 1)));
    send_rx(PREAMBLE_B2, 1'($urandom_range(0, 1)));
    send_frame_body(FB - PREAMBLE_LEN);
  endtask

  task automatic short_phase(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          b = SINGLE_LO + 8'($urandom_range(0, 7));
          send_good(b);
        end
        3, 4, 5: begin
          b = PAIR_LO + 8'($urandom_range(0, 2));
          send_good(b);
          b = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 5) == 0) send_bad(b);
          else send_good(b);
        end
        6: send_bad(8'($urandom_range(0, 255)));
        default: send_good(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic frame_phase(input int unsigned frames);
    repeat (frames) begin
      repeat ($urandom_range(0, 3)) begin
        send_rx(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      // broken preamble now and then
      if ($urandom_range(0, 4) == 0) begin
        send_rx(PREAMBLE_B0, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1)) send_rx(PREAMBLE_B1, 1'($urandom_range(0, 1)));
        send_rx(8'($urandom_range(2, 255)), 1'($urandom_range(0, 1)));
      end
      send_frame();
    end
  endtask

  initial begin
    int unsigned start_cnt;
    bit          pressure_done;
    logic        mode;
    pressure_done = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: short mode extremes, parity drops, ignored bytes
    set_protocol(1'b0);
    send_good(SINGLE_LO);
    send_good(SINGLE_HI);
    send_good(PAIR_LO);
    send_good(8'h00);
    send_good(PAIR_HI);
    send_bad(8'hFF);
    send_good(PAIR_HI);
    send_good(8'hFF);
    send_bad(8'h39);
    send_good(8'h2F);
    send_good(8'h3B);
    send_good(8'h39);
    // pending pair survives a detour through frame mode
    set_protocol(1'b1);
    send_rx(PREAMBLE_B0, 1'b1);
    send_rx(PREAMBLE_B1, 1'b0);
    send_rx(PREAMBLE_B2, 1'b1);
    send_rx(8'h00, 1'b0);
    send_rx(8'hFF, 1'b1);
    set_protocol(1'b0);
    send_good(8'hA5);
    set_protocol(1'b1);
    send_rx(8'h55, 1'b0);
    send_frame_body(FB - PREAMBLE_LEN - 3);

    // random phases
    start_cnt = 0;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      mode = pressure_done ? logic'($urandom_range(0, 1)) : 1'b1;
      if (rand_items + 60 > RAND_ITEMS) quiet = 1'b1;
      set_protocol(mode);
      start_cnt = sb.expected_words.size();
      if (mode) begin
        if (!pressure_done) begin
          hold_req = 1'b1;
          burst = 1'b1;
          frame_phase(3);
          burst = 1'b0;
          pressure_done = 1'b1;
          rand_items += 3 * FB;
        end else begin
          start_cnt = $urandom_range(1, 3);
          frame_phase(start_cnt);
          rand_items += start_cnt * (FB + 2);
        end
      end else begin
        start_cnt = $urandom_range(20, 40);
        short_phase(start_cnt);
        rand_items += start_cnt;
      end
    end

    settle();
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/dpfr_pkg.sv
hw/rtl/dpfr_ctrl.sv
hw/rtl/dpfr_datapath.sv
hw/rtl/dual_protocol_frame_receiver_top.sv
sim/tb_dual_protocol_frame_receiver_top.sv
